FILE: hw/rtl/cfcs_pkg.sv
package cfcs_pkg;

  // Byte codes that steer the scan.
  localparam logic [7:0] ByteRecordMark = 8'h3E;  // '>'
  localparam logic [7:0] ByteNewline    = 8'h0A;  // '\n'
  localparam logic [7:0] ByteUpperC     = 8'h43;  // 'C'
  localparam logic [7:0] ByteLowerC     = 8'h63;  // 'c'
  localparam logic [7:0] ByteUpperG     = 8'h47;  // 'G'
  localparam logic [7:0] ByteLowerG     = 8'h67;  // 'g'

  // Saturation top of positions, lengths and counts.
  localparam logic [31:0] Top32 = 32'hFFFF_FFFF;

  // Kind codes of a result item.
  localparam logic [1:0] KindSite     = 2'd0;
  localparam logic [1:0] KindSummary  = 2'd1;
  localparam logic [1:0] KindNoRecord = 2'd2;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ordinal;
    logic [31:0] position;
    logic [31:0] length;
    logic [31:0] count;
    logic        last;
  } result_t;

  // Results produced by one byte, packed from the first slot up.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

FILE: hw/rtl/cfcs_scan_core.sv
module cfcs_scan_core #(
  parameter int RECORD_ID_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           file_byte,
  input  logic                 is_final_byte,
  output cfcs_pkg::push_t      push
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_HEADER = 3'b010,
    MODE_SEQ    = 3'b100
  } mode_t;

  mode_t                      scan_mode, scan_mode_next;
  logic                       previous_was_c, previous_was_c_next;
  logic [31:0]                sequence_position, sequence_position_next;
  logic [31:0]                sites_in_record, sites_in_record_next;
  logic [RECORD_ID_BITS-1:0]  current_record, current_record_next;

  logic                       in_record;
  logic                       is_mark, is_newline, is_g, is_c;
  logic                       has_first;
  cfcs_pkg::result_t          res_a, res_fin;
  logic [31:0]                cur_ext, next_ext;
  logic [31:0]                c_pos;

  assign is_mark    = (file_byte == cfcs_pkg::ByteRecordMark);
  assign is_newline = (file_byte == cfcs_pkg::ByteNewline);
  assign is_g       = (file_byte == cfcs_pkg::ByteUpperG) || (file_byte == cfcs_pkg::ByteLowerG);
  assign is_c       = (file_byte == cfcs_pkg::ByteUpperC) || (file_byte == cfcs_pkg::ByteLowerC);
  assign in_record  = (scan_mode == MODE_HEADER) || (scan_mode == MODE_SEQ);
  assign cur_ext    = 32'(current_record);
  assign next_ext   = 32'(current_record_next);
  assign c_pos      = ((sequence_position < cfcs_pkg::Top32) && (sequence_position != 32'd0))
                      ? sequence_position - 32'd1 : cfcs_pkg::Top32;

  // Byte-level scan: state update and the result raised before end of file.
  always_comb begin
    scan_mode_next         = scan_mode;
    previous_was_c_next    = previous_was_c;
    sequence_position_next = sequence_position;
    sites_in_record_next   = sites_in_record;
    current_record_next    = current_record;
    has_first              = 1'b0;
    res_a                  = '0;
    if (is_mark) begin
      if (in_record) begin
        has_first           = 1'b1;
        res_a.kind          = cfcs_pkg::KindSummary;
        res_a.ordinal       = cur_ext[15:0];
        res_a.length        = sequence_position;
        res_a.count         = sites_in_record;
        current_record_next = current_record + 1'b1;
      end else begin
        current_record_next = '0;
      end
      scan_mode_next         = MODE_HEADER;
      previous_was_c_next    = 1'b0;
      sequence_position_next = '0;
      sites_in_record_next   = '0;
    end else begin
      case (scan_mode)
        MODE_HEADER: begin
          if (is_newline) begin
            scan_mode_next = MODE_SEQ;
          end
        end
        MODE_SEQ: begin
          if (!is_newline) begin
            if (previous_was_c && is_g) begin
              has_first      = 1'b1;
              res_a.kind     = cfcs_pkg::KindSite;
              res_a.ordinal  = cur_ext[15:0];
              res_a.position = c_pos;
              if (sites_in_record < cfcs_pkg::Top32) begin
                sites_in_record_next = sites_in_record + 32'd1;
              end
            end
            previous_was_c_next = is_c;
            if (sequence_position < cfcs_pkg::Top32) begin
              sequence_position_next = sequence_position + 32'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // End-of-file result, taken from the state after this byte.
  always_comb begin
    res_fin      = '0;
    res_fin.last = 1'b1;
    if ((scan_mode_next == MODE_HEADER) || (scan_mode_next == MODE_SEQ)) begin
      res_fin.kind    = cfcs_pkg::KindSummary;
      res_fin.ordinal = next_ext[15:0];
      res_fin.length  = sequence_position_next;
      res_fin.count   = sites_in_record_next;
    end else begin
      res_fin.kind = cfcs_pkg::KindNoRecord;
    end
  end

  // Pack the results of this byte from the first slot up.
  always_comb begin
    push = '0;
    if (step) begin
      if (has_first) begin
        push.first      = res_a;
        push.first.last = !is_final_byte;
        push.second     = res_fin;
        push.num        = is_final_byte ? 2'd2 : 2'd1;
      end else if (is_final_byte) begin
        push.first = res_fin;
        push.num   = 2'd1;
      end
    end
  end

  // State registers; the last byte of a file returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode         <= MODE_IDLE;
      previous_was_c    <= 1'b0;
      sequence_position <= '0;
      sites_in_record   <= '0;
      current_record    <= '0;
    end else if (step) begin
      if (is_final_byte) begin
        scan_mode         <= MODE_IDLE;
        previous_was_c    <= 1'b0;
        sequence_position <= '0;
        sites_in_record   <= '0;
        current_record    <= '0;
      end else begin
        scan_mode         <= scan_mode_next;
        previous_was_c    <= previous_was_c_next;
        sequence_position <= sequence_position_next;
        sites_in_record   <= sites_in_record_next;
        current_record    <= current_record_next;
      end
    end
  end

endmodule

FILE: hw/rtl/cfcs_result_queue.sv
module cfcs_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  cfcs_pkg::push_t    push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output cfcs_pkg::result_t  out_item
);

  cfcs_pkg::result_t entries [4];
  logic [1:0]        head, tail;
  logic [2:0]        fill, fill_next;
  logic              pop;

  // Room for the two results a single byte can raise.
  assign room      = (fill <= 3'd2);
  assign out_valid = (fill != 3'd0);
  assign out_item  = entries[head];
  assign pop       = out_valid && out_ready;
  assign fill_next = fill + 3'(push.num) - 3'(pop);

  // Result storage, written at the tail with up to two items.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entries[tail] <= push.first;
    end
    if (push.num == 2'd2) begin
      entries[tail + 2'd1] <= push.second;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + push.num;
      if (pop) begin
        head <= head + 2'd1;
      end
      fill <= fill_next;
    end
  end

endmodule

FILE: hw/rtl/fasta_cpg_site_scanner_unit.sv
// FASTA CpG site scanner. Bytes of a FASTA file enter on the slave stream,
// one item per byte, with s_tlast on the last byte of the file. A byte is
// accepted whenever the input register is empty or its byte is scanned. The
// registered input byte is scanned and its results written into a four-entry
// result queue, whose head is offered on the master stream. Each CpG pair
// gives a site item with the C position, each record end gives a summary,
// and a file without a record gives a no-record item; m_tlast marks the
// last result of a byte. A byte can raise two results, each its own output
// item, so the sustained rate is one byte per cycle only while each byte
// gives at most one result and m_tready is high, and input stalls whenever
// the queue holds more than two results.
module fasta_cpg_site_scanner_unit #(
  parameter int RECORD_ID_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Byte stream in.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] file_byte
  input  logic         s_tlast,   // is_final_byte
  // Result stream out.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // record_ordinal, site_position, sequence_length, site_count
  output logic [1:0]   m_tuser,   // result_kind
  output logic         m_tlast    // last_of_run
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_final;
  logic              room;
  logic              fire;
  cfcs_pkg::push_t   push;
  cfcs_pkg::result_t head_item;

  assign fire     = in_valid && room;
  assign s_tready = !in_valid || fire;

  // Input item register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_final <= s_tlast;
    end
  end

  cfcs_scan_core #(
    .RECORD_ID_BITS(RECORD_ID_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (fire),
    .file_byte     (in_byte),
    .is_final_byte (in_final),
    .push          (push)
  );

  cfcs_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (head_item)
  );

  // Result item onto the master stream.
  assign m_tdata = {head_item.count, head_item.length, head_item.position, head_item.ordinal};
  assign m_tuser = head_item.kind;
  assign m_tlast = head_item.last;

endmodule
